// ----- rtl/psc_pkg.sv -----
// ----------------------------------------------------------------------------
// psc_pkg
// shared types, constants and helpers for the pressure compensation pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package psc_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned RAW_W    = 20;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned SQ_W     = 19;
  localparam int unsigned DIV_STEPS = DATA_W;

  localparam logic [DATA_W-1:0] PC_BASE  = 32'd1048576;
  localparam logic [DATA_W-1:0] PC_SCALE = 32'd3125;

  // apb register map, word index
  localparam int unsigned APB_ADDR_W = 4;
  localparam logic [1:0] REG_P7 = 2'd0;
  localparam logic [1:0] REG_P8 = 2'd1;
  localparam logic [1:0] REG_P9 = 2'd2;

  // control that travels with each beat through the pipeline
  typedef struct packed {
    logic vld;  // stage holds a live beat
    logic dbz;  // divisor was zero
    logic dbl;  // doubling applied after the division
  } psc_ctrl_t;

  function automatic logic [DATA_W-1:0] sx16(input logic [COEF_W-1:0] v);
    sx16 = {{(DATA_W-COEF_W){v[COEF_W-1]}}, v};
  endfunction

  function automatic logic [DATA_W-1:0] asr(input logic [DATA_W-1:0] v,
                                            input int unsigned s);
    asr = DATA_W'($signed(v) >>> s);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/psc_front.sv -----
// ----------------------------------------------------------------------------
// psc_front
// two stages: offset subtraction, then scaling by 3125 and numerator select
// ----------------------------------------------------------------------------
`default_nettype none

module psc_front
  import psc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire logic              in_vld,
  input  wire logic [RAW_W-1:0]  raw_pressure,
  input  wire logic [DATA_W-1:0] divisor_term,
  input  wire logic [DATA_W-1:0] offset_term,
  output psc_ctrl_t              out_ctrl,
  output logic [DATA_W-1:0]      out_num,
  output logic [DATA_W-1:0]      out_div
);

  logic              vld1;
  logic [DATA_W-1:0] base1;
  logic [DATA_W-1:0] div1;
  logic [DATA_W-1:0] base_next;
  logic [DATA_W-1:0] prod_next;

  assign base_next = PC_BASE - {{(DATA_W-RAW_W){1'b0}}, raw_pressure} - asr(offset_term, 12);
  assign prod_next = base1 * PC_SCALE;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1         <= 1'b0;
      out_ctrl.vld <= 1'b0;
    end else if (advance) begin
      vld1         <= in_vld;
      out_ctrl.vld <= vld1;
    end
    if (advance) begin
      base1        <= base_next;
      div1         <= divisor_term;
      // below half the range the doubling fits before the division
      out_ctrl.dbz <= (div1 == '0);
      out_ctrl.dbl <= prod_next[DATA_W-1];
      out_num      <= prod_next[DATA_W-1] ? prod_next : {prod_next[DATA_W-2:0], 1'b0};
      out_div      <= div1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/psc_div_step.sv -----
// ----------------------------------------------------------------------------
// psc_div_step
// one registered step of the restoring divider, one quotient bit
// ----------------------------------------------------------------------------
`default_nettype none

module psc_div_step
  import psc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire psc_ctrl_t         in_ctrl,
  input  wire logic [DATA_W-1:0] in_rem,
  input  wire logic [DATA_W-1:0] in_word,
  input  wire logic [DATA_W-1:0] in_div,
  output psc_ctrl_t              out_ctrl,
  output logic [DATA_W-1:0]      out_rem,
  output logic [DATA_W-1:0]      out_word,
  output logic [DATA_W-1:0]      out_div
);

  logic [DATA_W:0]   trial;
  logic [DATA_W+1:0] diff;
  logic              ge;

  // word shifts dividend bits out at the top and quotient bits in at the bottom
  assign trial = {in_rem, in_word[DATA_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, in_div};
  assign ge    = ~diff[DATA_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctrl.vld <= 1'b0;
    end else if (advance) begin
      out_ctrl.vld <= in_ctrl.vld;
    end
    if (advance) begin
      out_ctrl.dbz <= in_ctrl.dbz;
      out_ctrl.dbl <= in_ctrl.dbl;
      out_rem      <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      out_word     <= {in_word[DATA_W-2:0], ge};
      out_div      <= in_div;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/psc_divider.sv -----
// ----------------------------------------------------------------------------
// psc_divider
// fully pipelined 32 by 32 unsigned restoring divider
// ----------------------------------------------------------------------------
`default_nettype none

module psc_divider
  import psc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire psc_ctrl_t         in_ctrl,
  input  wire logic [DATA_W-1:0] in_num,
  input  wire logic [DATA_W-1:0] in_div,
  output psc_ctrl_t              out_ctrl,
  output logic [DATA_W-1:0]      out_quot
);

  psc_ctrl_t         ctrl [DIV_STEPS+1];
  logic [DATA_W-1:0] rem  [DIV_STEPS+1];
  logic [DATA_W-1:0] word [DIV_STEPS+1];
  logic [DATA_W-1:0] dvs  [DIV_STEPS+1];

  assign ctrl[0] = in_ctrl;
  assign rem[0]  = '0;
  assign word[0] = in_num;
  assign dvs[0]  = in_div;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    psc_div_step u_step (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .in_ctrl  (ctrl[i]),
      .in_rem   (rem[i]),
      .in_word  (word[i]),
      .in_div   (dvs[i]),
      .out_ctrl (ctrl[i+1]),
      .out_rem  (rem[i+1]),
      .out_word (word[i+1]),
      .out_div  (dvs[i+1])
    );
  end

  assign out_ctrl = ctrl[DIV_STEPS];
  assign out_quot = word[DIV_STEPS];

endmodule

`default_nettype wire

// ----- rtl/psc_correct.sv -----
// ----------------------------------------------------------------------------
// psc_correct
// second-order correction with p7, p8, p9 over four stages
// ----------------------------------------------------------------------------
`default_nettype none

module psc_correct
  import psc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire psc_ctrl_t         in_ctrl,
  input  wire logic [DATA_W-1:0] in_quot,
  input  wire logic [COEF_W-1:0] coef_p7,
  input  wire logic [COEF_W-1:0] coef_p8,
  input  wire logic [COEF_W-1:0] coef_p9,
  output logic                   out_vld,
  output logic [DATA_W-1:0]      pressure_pa,
  output logic                   divide_by_zero
);

  logic [DATA_W-1:0]     p_in;
  logic [DATA_W-4:0]     p_sh3;
  logic [2*DATA_W-7:0]   sq_full;
  logic [DATA_W-1:0]     lin_next;
  logic [DATA_W-1:0]     quad_next;
  logic [DATA_W-1:0]     sum_next;
  logic [DATA_W-1:0]     p_next;

  logic [2:0]            vld;
  logic [2:0]            dbz;
  logic [DATA_W-1:0]     p1, p2, p3;
  logic [SQ_W-1:0]       sq1;
  logic [DATA_W-1:0]     lin1;
  logic [DATA_W-1:0]     quad2;
  logic [DATA_W-1:0]     lin2;
  logic [DATA_W-1:0]     sum3;

  assign p_in      = in_ctrl.dbl ? {in_quot[DATA_W-2:0], 1'b0} : in_quot;
  assign p_sh3     = p_in[DATA_W-1:3];
  assign sq_full   = p_sh3 * p_sh3;
  assign lin_next  = {2'b00, p_in[DATA_W-1:2]} * sx16(coef_p8);
  assign quad_next = sx16(coef_p9) * {{(DATA_W-SQ_W){1'b0}}, sq1};
  assign sum_next  = asr(quad2, 12) + lin2 + sx16(coef_p7);
  assign p_next    = dbz[2] ? '0 : p3 + asr(sum3, 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else if (advance) begin
      vld     <= {vld[1:0], in_ctrl.vld};
      out_vld <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dbz            <= {dbz[1:0], in_ctrl.dbz};
      // stage 1: square and linear products
      p1             <= p_in;
      sq1            <= sq_full[DATA_W-1:13];
      lin1           <= lin_next;
      // stage 2: quadratic product
      p2             <= p1;
      quad2          <= quad_next;
      lin2           <= asr(lin1, 13);
      // stage 3: correction sum
      p3             <= p2;
      sum3           <= sum_next;
      // stage 4: final add
      pressure_pa    <= p_next;
      divide_by_zero <= dbz[2];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pressure_sensor_compensation.sv -----
// ----------------------------------------------------------------------------
// pressure_sensor_compensation
// compensated pressure in pascals from a raw reading and two earlier terms
// ----------------------------------------------------------------------------
// The block takes one beat per clock while the output is not stalled and
// returns one result beat for each input beat, in order. The divider is a
// 32-stage restoring divider that resolves one quotient bit per stage, fed by
// two front stages (offset subtraction, scaling by 3125) and followed by four
// correction stages, the last being the output register. The
// whole pipeline moves together: it advances whenever the output register is
// empty or its beat is being taken, so s_tready drops only while a result waits
// at the output. A zero divisor term gives pressure 0 with divide_by_zero set.
// Coefficients p7, p8 and p9 sit at byte addresses 0, 4 and 8 of the apb port,
// 16-bit signed in the low bits of pwdata; write them only while no beat is in
// flight.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_sensor_compensation
  import psc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [87:0]           s_tdata,   // raw_pressure[19:0], divisor_term[51:20],
                                                // offset_term[83:52], zero pad
  // output stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [31:0]                m_tdata,   // pressure_pa[31:0]
  output logic [0:0]                 m_tuser,   // divide_by_zero[0]
  // apb configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [COEF_W-1:0] coef_p7;
  logic [COEF_W-1:0] coef_p8;
  logic [COEF_W-1:0] coef_p9;
  logic              cfg_wr;
  logic              advance;

  psc_ctrl_t         front_ctrl;
  logic [DATA_W-1:0] front_num;
  logic [DATA_W-1:0] front_div;
  psc_ctrl_t         div_ctrl;
  logic [DATA_W-1:0] div_quot;
  logic              out_vld;
  logic [DATA_W-1:0] out_pa;
  logic              out_dbz;

  // ---- configuration registers ----
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_p7 <= '0;
      coef_p8 <= '0;
      coef_p9 <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_P7:  coef_p7 <= pwdata[COEF_W-1:0];
        REG_P8:  coef_p8 <= pwdata[COEF_W-1:0];
        REG_P9:  coef_p9 <= pwdata[COEF_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  // read back sign extended, as the coefficients are signed
  always_comb begin
    case (paddr[3:2])
      REG_P7:  prdata = sx16(coef_p7);
      REG_P8:  prdata = sx16(coef_p8);
      REG_P9:  prdata = sx16(coef_p9);
      default: prdata = '0;
    endcase
  end

  // ---- pipeline flow control ----
  // every stage moves on the same enable; output register doubles as last stage
  assign advance  = ~m_tvalid | m_tready;
  assign s_tready = advance;

  // ---- front: offset subtraction and scaling ----
  psc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .in_vld       (s_tvalid),
    .raw_pressure (s_tdata[19:0]),
    .divisor_term (s_tdata[51:20]),
    .offset_term  (s_tdata[83:52]),
    .out_ctrl     (front_ctrl),
    .out_num      (front_num),
    .out_div      (front_div)
  );

  // ---- divider: one quotient bit per stage ----
  psc_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_ctrl  (front_ctrl),
    .in_num   (front_num),
    .in_div   (front_div),
    .out_ctrl (div_ctrl),
    .out_quot (div_quot)
  );

  // ---- correction with p7, p8, p9 ----
  psc_correct u_correct (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .in_ctrl        (div_ctrl),
    .in_quot        (div_quot),
    .coef_p7        (coef_p7),
    .coef_p8        (coef_p8),
    .coef_p9        (coef_p9),
    .out_vld        (out_vld),
    .pressure_pa    (out_pa),
    .divide_by_zero (out_dbz)
  );

  assign m_tvalid   = out_vld;
  assign m_tdata    = out_pa;
  assign m_tuser[0] = out_dbz;

endmodule

`default_nettype wire

// ----- rtl/psc_checker.sv -----
// ----------------------------------------------------------------------------
// psc_checker
// port-level checks for the pressure compensation block
// ----------------------------------------------------------------------------
`default_nettype none

module psc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [0:0]  m_tuser
);

  // output empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // a flagged zero divisor always reports zero pressure
  a_dbz_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == 32'd0))
    else $error("divide by zero beat with nonzero pressure");

  // pipeline stalls on input while a result waits, and flows otherwise
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled output beat changed");

endmodule

bind pressure_sensor_compensation psc_checker u_psc_checker (.*);

`default_nettype wire

// ----- sim/pressure_sensor_compensation_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pressure_sensor_compensation_checker
// watches the stream and apb channels, predicts each result and compares it
// ----------------------------------------------------------------------------
// Coefficient writes seen on the apb port update a local copy of p7, p8 and
// p9. Every accepted input beat is turned into an expected pressure and flag,
// queued in order, and matched against the next accepted output beat.
// ----------------------------------------------------------------------------

module pressure_sensor_compensation_checker
  import psc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  input  wire logic                  s_tready,
  input  wire logic [87:0]           s_tdata,   // raw_pressure[19:0], divisor_term[51:20],
                                                // offset_term[83:52], zero pad
  input  wire logic                  m_tvalid,
  input  wire logic                  m_tready,
  input  wire logic [31:0]           m_tdata,   // pressure_pa[31:0]
  input  wire logic [0:0]            m_tuser,   // divide_by_zero[0]
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic                  pready,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output int                         fail_count,
  output int                         pending_count,
  output int                         results_checked
);

  localparam logic [DATA_W-1:0] DOUBLE_AFTER_SPLIT = 32'h8000_0000;

  typedef struct packed {
    logic [DATA_W-1:0] pressure_pa;
    logic              divide_by_zero;
  } pressure_result_t;

  logic [COEF_W-1:0] p7_copy;
  logic [COEF_W-1:0] p8_copy;
  logic [COEF_W-1:0] p9_copy;
  pressure_result_t  expected_pressure_q[$];

  initial begin
    fail_count      = 0;
    pending_count   = 0;
    results_checked = 0;
    p7_copy         = '0;
    p8_copy         = '0;
    p9_copy         = '0;
  end

  function automatic logic [DATA_W-1:0] shift_arith(input logic [DATA_W-1:0] v,
                                                    input int unsigned s);
    logic signed [DATA_W-1:0] sv;
    sv = v;
    shift_arith = sv >>> s;
  endfunction

  // compensated pressure for one reading under the given coefficients
  function automatic pressure_result_t compensate(input logic [RAW_W-1:0]  raw,
                                                  input logic [DATA_W-1:0] dvs,
                                                  input logic [DATA_W-1:0] ofs,
                                                  input logic [COEF_W-1:0] c7,
                                                  input logic [COEF_W-1:0] c8,
                                                  input logic [COEF_W-1:0] c9);
    logic [DATA_W-1:0] k7, k8, k9;
    logic [DATA_W-1:0] scaled, p, eighth, sq, t1, t2, sum;
    pressure_result_t  r;
    k7 = {{(DATA_W-COEF_W){c7[COEF_W-1]}}, c7};
    k8 = {{(DATA_W-COEF_W){c8[COEF_W-1]}}, c8};
    k9 = {{(DATA_W-COEF_W){c9[COEF_W-1]}}, c9};
    if (dvs == '0) begin
      r.pressure_pa    = '0;
      r.divide_by_zero = 1'b1;
      return r;
    end
    scaled = PC_BASE - {{(DATA_W-RAW_W){1'b0}}, raw};
    scaled = scaled - shift_arith(ofs, 12);
    p      = scaled * PC_SCALE;
    // doubling goes first while it cannot overflow
    if (p < DOUBLE_AFTER_SPLIT) begin
      p = (p << 1) / dvs;
    end else begin
      p = (p / dvs) * 32'd2;
    end
    eighth = p >> 3;
    sq     = eighth * eighth;
    sq     = sq >> 13;
    t1     = k9 * sq;
    t1     = shift_arith(t1, 12);
    t2     = (p >> 2) * k8;
    t2     = shift_arith(t2, 13);
    sum    = t1 + t2 + k7;
    r.pressure_pa    = p + shift_arith(sum, 4);
    r.divide_by_zero = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    pressure_result_t want;
    int               n_bad;
    int               n_push;
    int               n_pop;
    n_bad  = 0;
    n_push = 0;
    n_pop  = 0;
    if (rst) begin
      p7_copy = '0;
      p8_copy = '0;
      p9_copy = '0;
      expected_pressure_q.delete();
      pending_count <= 0;
    end else begin
      // coefficient write, low 16 bits only, unknown index ignored
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_ADDR_W-1:2])
          REG_P7: p7_copy = pwdata[COEF_W-1:0];
          REG_P8: p8_copy = pwdata[COEF_W-1:0];
          REG_P9: p9_copy = pwdata[COEF_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        expected_pressure_q.push_back(compensate(s_tdata[19:0], s_tdata[51:20],
                                                 s_tdata[83:52], p7_copy, p8_copy,
                                                 p9_copy));
        n_push = 1;
      end
      if (m_tvalid && m_tready) begin
        if (expected_pressure_q.size() == 0) begin
          $error("result beat with nothing expected: pressure_pa %0d divide_by_zero %0b",
                 m_tdata, m_tuser[0]);
          n_bad++;
        end else begin
          want  = expected_pressure_q.pop_front();
          n_pop = 1;
          if (m_tdata !== want.pressure_pa) begin
            $error("pressure_pa mismatch: expected %0d, actual %0d",
                   want.pressure_pa, m_tdata);
            n_bad++;
          end
          if (m_tuser[0] !== want.divide_by_zero) begin
            $error("divide_by_zero mismatch: expected %0b, actual %0b",
                   want.divide_by_zero, m_tuser[0]);
            n_bad++;
          end
        end
      end
      pending_count   <= pending_count + n_push - n_pop;
      results_checked <= results_checked + n_pop;
      fail_count      <= fail_count + n_bad;
    end
  end

endmodule

// ----- sim/pressure_sensor_compensation_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pressure_sensor_compensation_tb
// stream and apb stimulus for the pressure compensation block
// ----------------------------------------------------------------------------
// A short directed run covers field extremes, a zero divisor and both sides of
// the doubling split under the reset coefficients. Then eight coefficient
// sets, extremes among them, each get a batch of random readings, mostly
// sensor-like with wide noise, tiny and zero divisors mixed in. Both stream
// sides idle at random except in some batches; the checker does the scoring.
// ----------------------------------------------------------------------------

module pressure_sensor_compensation_tb;
  import psc_pkg::*;

  // paddr index with no register behind it
  localparam logic [1:0] REG_UNUSED     = 2'd3;
  localparam int         N_COEF_SETS    = 8;
  localparam int         BATCH_READINGS = 50;
  // wait after the last result, with margin over the pipeline depth
  localparam int         SETTLE_CYCLES  = 50;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [87:0]           s_tdata;   // raw_pressure[19:0], divisor_term[51:20],
                                    // offset_term[83:52], zero pad
  logic                  m_tvalid;
  logic                  m_tready;
  logic [31:0]           m_tdata;   // pressure_pa[31:0]
  logic [0:0]            m_tuser;   // divide_by_zero[0]
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  int fail_count;
  int pending_count;
  int results_checked;

  // stimulus bookkeeping, printed in the summary
  int readings_sent;
  int zero_div_sent;

  // idling switches, flipped per batch
  logic source_idle_en;
  logic sink_idle_en;

  pressure_sensor_compensation DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  pressure_sensor_compensation_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .results_checked (results_checked)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // output side back-pressure, one nonblocking update per edge
  initial begin
    int stall_left;
    stall_left = 0;
    m_tready   = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left == 0 && sink_idle_en) stall_left = pick_gap();
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // one coefficient write: setup cycle then access cycle, junk in the upper half
  task automatic write_coef(input logic [1:0] reg_idx, input logic [COEF_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // one reading, held until the block takes it
  task automatic send_reading(input logic [RAW_W-1:0]  raw,
                              input logic [DATA_W-1:0] dvs,
                              input logic [DATA_W-1:0] ofs);
    int gap;
    gap = source_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, ofs, dvs, raw};
    do @(posedge clk); while (!s_tready);
    readings_sent++;
    if (dvs == '0) zero_div_sent++;
  endtask

  // pick one random reading from a mix of shapes
  task automatic send_random_reading();
    logic [RAW_W-1:0]  raw;
    logic [DATA_W-1:0] dvs;
    logic [DATA_W-1:0] ofs;
    logic [DATA_W-1:0] edges[5];
    int                r;
    edges = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001};
    r = $urandom_range(0, 99);
    raw = RAW_W'($urandom);
    dvs = $urandom;
    ofs = $urandom;
    if (r < 55) begin
      // sensor-like: realistic raw and terms near what the earlier stages make
      raw = RAW_W'($urandom_range(200000, 800000));
      dvs = $urandom_range(20000, 60000);
      ofs = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    end else if (r < 80) begin
      // fully random fields
    end else if (r < 90) begin
      // tiny divisor, large wrapping quotient
      dvs = $urandom_range(1, 16);
    end else if (r < 95) begin
      dvs = '0;
    end else begin
      // corner values on every field
      raw = ($urandom_range(0, 1) == 0) ? '0 : '1;
      dvs = edges[$urandom_range(1, 4)];
      ofs = edges[$urandom_range(0, 4)];
    end
    send_reading(raw, dvs, ofs);
  endtask

  // release the input, wait for every result, then let the pipe settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // coefficient sets {p7, p8, p9}, extremes among them
  task automatic load_coef_set(input int idx);
    logic [COEF_W-1:0] c7, c8, c9;
    case (idx)
      0: begin c7 = 16'h3C8C; c8 = 16'hC6F8; c9 = 16'h1770; end  // typical trim
      1: begin c7 = 16'h7FFF; c8 = 16'h7FFF; c9 = 16'h7FFF; end
      2: begin c7 = 16'h8000; c8 = 16'h8000; c9 = 16'h8000; end
      3: begin c7 = 16'h7FFF; c8 = 16'h8000; c9 = 16'hFFFF; end
      4: begin c7 = 16'hFFFF; c8 = 16'h0001; c9 = 16'h8000; end
      5: begin c7 = 16'($urandom); c8 = 16'($urandom); c9 = 16'($urandom); end
      6: begin c7 = 16'($urandom); c8 = 16'($urandom); c9 = 16'($urandom); end
      default: begin c7 = 16'h3C8C; c8 = 16'hC6F8; c9 = 16'h1770; end
    endcase
    write_coef(REG_P7, c7);
    write_coef(REG_P8, c8);
    write_coef(REG_P9, c9);
    // write to the unused index must leave the three coefficients alone
    if (idx == 2) write_coef(REG_UNUSED, 16'h1234);
  endtask

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    source_idle_en = 1'b0;
    sink_idle_en   = 1'b0;
    readings_sent  = 0;
    zero_div_sent  = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed readings under the reset coefficients, no idling
    send_reading(20'd500000, 32'd32000, 32'd0);          // doubling before division
    send_reading(20'd0, 32'd32000, 32'd0);               // doubling after division
    send_reading(20'hFFFFF, 32'd32000, 32'd0);
    send_reading(20'd400000, 32'd0, 32'd12345);          // zero divisor
    send_reading(20'hFFFFF, 32'd0, 32'hFFFF_FFFF);       // zero divisor, all ones elsewhere
    send_reading(20'd400000, 32'd1, 32'd0);
    send_reading(20'd400000, 32'hFFFF_FFFF, 32'd0);
    send_reading(20'd400000, 32'h8000_0000, 32'd0);
    send_reading(20'd400000, 32'h7FFF_FFFF, 32'd4096);
    send_reading(20'd0, 32'd30000, 32'h8000_0000);       // most negative offset
    send_reading(20'hFFFFF, 32'd30000, 32'h7FFF_FFFF);   // most positive offset
    send_reading(20'd350000, 32'd35000, 32'hFFFF_FFFF);  // offset -1
    send_reading(20'd350000, 32'd35000, 32'hFFFF_F000);  // offset -4096
    send_reading(20'hAAAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_reading(20'h55555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_reading(20'd0, 32'd1, 32'h8000_0000);           // largest wrap
    drain();

    // random batches, one coefficient set each; every fourth batch runs flat out
    for (int set_idx = 0; set_idx < N_COEF_SETS; set_idx++) begin
      load_coef_set(set_idx);
      source_idle_en = (set_idx % 4 != 1);
      sink_idle_en   = (set_idx % 4 != 1);
      repeat (BATCH_READINGS) send_random_reading();
      drain();
    end

    $display("covered %0d readings (%0d with zero divisor) over %0d coefficient sets",
             readings_sent, zero_div_sent, N_COEF_SETS + 1);
    $display("%0d result beats compared, %0d mismatches", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hard stop in case a handshake never completes
  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- pressure_sensor_compensation.f -----
rtl/psc_pkg.sv
rtl/psc_front.sv
rtl/psc_div_step.sv
rtl/psc_divider.sv
rtl/psc_correct.sv
rtl/pressure_sensor_compensation.sv
rtl/psc_checker.sv
sim/pressure_sensor_compensation_checker.sv
sim/pressure_sensor_compensation_tb.sv
